@@ hw/rtl/lfu_pkg.sv @@
// Package for the LFU cache store: sizes, payload structs and the
// command/status structs between controller and datapath. No dependencies.
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                         command;
        logic signed [KEY_BITS-1:0]   key;
        logic signed [VALUE_BITS-1:0] value;
    } lfu_in_t;

    typedef struct packed {
        logic                         found;
        logic signed [VALUE_BITS-1:0] read_value;
    } lfu_out_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic touch;
        logic write_val;
        logic scan_start;
        logic scan_step;
        logic evict;
        logic insert;
        logic load_out;
    } lfu_cmd_t;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic need_evict;
        logic cap_zero;
        logic scan_last;
        logic out_free;
    } lfu_status_t;

endpackage

@@ hw/rtl/lfu_ctrl.sv @@
// Controller state machine of the LFU cache store.
// Depends on lfu_pkg for the command and status structs.
module lfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lfu_pkg::lfu_status_t status,
    output lfu_pkg::lfu_cmd_t    cmd
);
    import lfu_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOK   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_RESP   = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_EVICT  = 7'b0100000,
        ST_INSERT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.match  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!status.is_put)
                    state_next = ST_RESP;
                else if (status.cap_zero)
                    state_next = ST_IDLE;
                else if (status.hit)
                begin
                    cmd.touch     = 1'b1;
                    cmd.write_val = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.need_evict)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                    state_next = ST_INSERT;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.touch    = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hw/rtl/lfu_datapath.sv @@
// Datapath of the LFU cache store: entry registers, key match, victim scan,
// count and recency updates, output register. Depends on lfu_pkg.
module lfu_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfu_pkg::lfu_in_t     in_data,
    input  logic                 cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
    input  lfu_pkg::lfu_cmd_t    cmd,
    output lfu_pkg::lfu_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lfu_pkg::lfu_out_t    out_data
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    lfu_in_t                item_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic [KEY_BITS-1:0]    key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0]  val_reg   [ENTRIES];
    logic [COUNT_BITS-1:0]  cnt_reg   [ENTRIES];
    logic [IDX_W-1:0]       rank_reg  [ENTRIES];
    logic [OCC_W-1:0]       occ_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   best_found_reg;
    logic                   out_valid_reg;
    lfu_out_t               out_reg;

    logic                   match_any;
    logic [IDX_W-1:0]       match_idx;
    logic                   free_any;
    logic [IDX_W-1:0]       free_idx;
    logic [31:0]            cap_eff;
    logic                   scan_better;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       victim_rank;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_reg[i] == KEY_BITS'(item_reg.key))
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign cap_eff = (32'(cap_reg) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_reg);
    assign hit_rank    = rank_reg[hit_idx_reg];
    assign victim_rank = rank_reg[best_idx_reg];
    assign scan_better = valid_reg[scan_idx_reg] &&
        (!best_found_reg ||
         {cnt_reg[scan_idx_reg], ~rank_reg[scan_idx_reg]} <
         {cnt_reg[best_idx_reg], ~rank_reg[best_idx_reg]});

    assign status.is_put     = (item_reg.command == CMD_PUT);
    assign status.hit        = hit_reg;
    assign status.need_evict = (32'(occ_reg) >= cap_eff);
    assign status.cap_zero   = (cap_reg == '0);
    assign status.scan_last  = (scan_idx_reg == LAST_IDX);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.match)
            hit_idx_reg <= match_idx;
        if (cmd.scan_start)
        begin
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
        end
        if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (scan_better)
                best_idx_reg <= scan_idx_reg;
        end
        if (cmd.load_out)
        begin
            out_reg.found      <= hit_reg;
            out_reg.read_value <= hit_reg ? val_reg[hit_idx_reg] : '0;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.touch && hit_reg)
            begin
                if (IDX_W'(i) == hit_idx_reg)
                begin
                    rank_reg[i] <= '0;
                    if (cnt_reg[i] != '1)
                        cnt_reg[i] <= cnt_reg[i] + COUNT_BITS'(1);
                    if (cmd.write_val)
                        val_reg[i] <= VALUE_BITS'(item_reg.value);
                end
                else if (valid_reg[i] && rank_reg[i] < hit_rank)
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
            end
            if (cmd.evict && valid_reg[i] && rank_reg[i] > victim_rank)
                rank_reg[i] <= rank_reg[i] - IDX_W'(1);
            if (cmd.insert && free_any)
            begin
                if (IDX_W'(i) == free_idx)
                begin
                    key_reg[i]  <= KEY_BITS'(item_reg.key);
                    val_reg[i]  <= VALUE_BITS'(item_reg.value);
                    cnt_reg[i]  <= COUNT_BITS'(1);
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i])
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            occ_reg        <= '0;
            cap_reg        <= CAP_RESET;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (cmd.match)
                hit_reg <= match_any;
            if (cmd.scan_start)
                best_found_reg <= 1'b0;
            if (cmd.scan_step && scan_better)
                best_found_reg <= 1'b1;
            if (cmd.evict && best_found_reg)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                occ_reg                 <= occ_reg - OCC_W'(1);
            end
            if (cmd.insert && free_any)
            begin
                valid_reg[free_idx] <= 1'b1;
                occ_reg             <= occ_reg + OCC_W'(1);
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/lfu_cache_store.sv @@
// Top level of the LFU cache store: joins controller and datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
//   channel  signals                        direction
//   in       in_valid/in_ready/in_data      item in (get or put)
//   out      out_valid/out_ready/out_data   get result out
//   cfg      cfg_we/cfg_wdata               capacity write
//
// A get passes the look, decide and response steps on its way to the result
// register. A put to a present key, or with capacity zero, ends after decide. A put
// of a new key into a full store then walks one entry a cycle for a victim, evicts, inserts.
// Reset clears valid flags, occupancy and sets capacity to 16.
// A get holds in its response step while the output register is full and out_ready is low.
module lfu_cache_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lfu_pkg::lfu_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lfu_pkg::lfu_out_t         out_data,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
    import lfu_pkg::*;

    lfu_cmd_t    cmd;
    lfu_status_t status;

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lfu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
